@@ design/neighbour_joining_tree_assert.svh @@
// Assertion macros shared by the checker file of the neighbour joining block.
`ifndef NEIGHBOUR_JOINING_TREE_ASSERT_SVH
`define NEIGHBOUR_JOINING_TREE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define NJT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define NJT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/nj_pkg.sv @@
// Shared constants, types and saturation helpers of the neighbour joining block.
`timescale 1ns / 1ps
package nj_pkg;

	localparam int MAX_TAXA = 64;
	localparam int IDX_W    = 6;
	localparam int DIST_W   = 32;
	localparam int SUM_W    = 40;
	localparam int NODE_W   = 7;
	localparam int WIDE_W   = 42;
	localparam int DIV_CNT_W = 6;

	localparam logic [NODE_W-1:0] TAXA_RESET = 7'd32;
	localparam logic [NODE_W-1:0] TAXA_MIN   = 7'd3;
	localparam logic [NODE_W-1:0] TAXA_MAX   = 7'd64;

	localparam logic REG_TAXA  = 1'b0;
	localparam logic REG_CLAMP = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_IN_RD,
		S_IN_ACC,
		S_IN_DIV,
		S_IN_DIVW,
		S_RND,
		S_SC_ROW,
		S_SC_ROWW,
		S_SC_RD,
		S_SC_CMP,
		S_JN_RD1,
		S_JN_RD2,
		S_JN_LAT,
		S_JN_CALC,
		S_MG_CHK,
		S_MG_RD2,
		S_MG_CALC,
		S_MG_UPD,
		S_MG_DIVW,
		S_MG_WR2,
		S_MG_FIN,
		S_MG_FDIV,
		S_MG_END,
		S_FN_SCAN,
		S_FN_RD,
		S_FN_RD2,
		S_FN_LAT,
		S_FN_CALC
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [IDX_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DIST_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = 42'sh0007FFFFFFF;
		lo = -hi - 42'sd1;
		if (x > hi) begin
			return 32'sh7FFFFFFF;
		end else if (x < lo) begin
			return 32'sh80000000;
		end
		return x[DIST_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = 42'sh07FFFFFFFFF;
		lo = -hi - 42'sd1;
		if (x > hi) begin
			return 40'sh7FFFFFFFFF;
		end else if (x < lo) begin
			return 40'sh8000000000;
		end
		return x[SUM_W-1:0];
	endfunction

endpackage

@@ design/nj_div.sv @@
// Shared restoring divider: signed 40-bit sum by a small count, one bit per cycle.
`timescale 1ns / 1ps
module nj_div (
	input  logic             clk,
	input  logic             arst_n,
	input  nj_pkg::div_req_t req,
	output nj_pkg::div_rsp_t rsp
);

	logic                              run_q;
	logic                              done_q;
	logic [nj_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [nj_pkg::SUM_W-1:0]          num_q;
	logic [nj_pkg::IDX_W-1:0]          rem_q;
	logic [nj_pkg::IDX_W-1:0]          den_q;
	logic                              neg_q;
	logic [nj_pkg::IDX_W:0]            trial;
	logic                              qbit;
	logic [nj_pkg::IDX_W:0]            diff;

	assign trial = {rem_q, num_q[nj_pkg::SUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(nj_pkg::SUM_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[nj_pkg::SUM_W-1];
			num_q <= req.dividend[nj_pkg::SUM_W-1] ? -req.dividend : req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (run_q) begin
			// shift one quotient bit in while the dividend bits shift out
			rem_q <= qbit ? diff[nj_pkg::IDX_W-1:0] : trial[nj_pkg::IDX_W-1:0];
			num_q <= {num_q[nj_pkg::SUM_W-2:0], qbit};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (neg_q) begin
			if (num_q > 40'h0080000000) begin
				rsp.quotient = 32'sh80000000;
			end else begin
				rsp.quotient = -num_q[nj_pkg::DIST_W-1:0];
			end
		end else begin
			if (num_q > 40'h007FFFFFFF) begin
				rsp.quotient = 32'sh7FFFFFFF;
			end else begin
				rsp.quotient = num_q[nj_pkg::DIST_W-1:0];
			end
		end
	end

endmodule

@@ design/neighbour_joining_tree.sv @@
// Top level of the neighbour joining block: loader, join sequencer and memories.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   row_index, column_index, distance_value, last_entry
//  out      source     out_valid / out_stall first_node, second_node, first_branch,
//                                            second_branch, last_join
//  cfg      sink       cfg_we                cfg_index, cfg_data
//
// An ordinary matrix beat is written straight into the distance memory. A beat with
// last_entry runs the whole tree build: row sums and divisions, then per round a scan
// and a merge; the shared bit-serial divider and the single distance memory port set
// the pace of each step.
// Reset clears the sequencer and output valid; memories are written before use.
// Each join waits in its output register while out_stall holds; the sequencer waits too.
`timescale 1ns / 1ps
module neighbour_joining_tree (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [6:0]                         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [nj_pkg::IDX_W-1:0]           row_index,
	input  logic [nj_pkg::IDX_W-1:0]           column_index,
	input  logic signed [nj_pkg::DIST_W-1:0]   distance_value,
	input  logic                               last_entry,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [nj_pkg::NODE_W-1:0]          first_node,
	output logic [nj_pkg::NODE_W-1:0]          second_node,
	output logic signed [nj_pkg::DIST_W-1:0]   first_branch,
	output logic signed [nj_pkg::DIST_W-1:0]   second_branch,
	output logic                               last_join
);

	localparam int AW = 2 * nj_pkg::IDX_W;

	nj_pkg::state_t state_q, state_d;

	logic [nj_pkg::NODE_W-1:0] taxa_q;
	logic                      clamp_q;

	// memories
	logic signed [nj_pkg::DIST_W-1:0] dist_mem [nj_pkg::MAX_TAXA*nj_pkg::MAX_TAXA];
	logic signed [nj_pkg::SUM_W-1:0]  sum_mem  [nj_pkg::MAX_TAXA];
	logic signed [nj_pkg::DIST_W-1:0] sep_mem  [nj_pkg::MAX_TAXA];
	logic [nj_pkg::NODE_W-1:0]        id_mem   [nj_pkg::MAX_TAXA];

	logic                             dist_we;
	logic [AW-1:0]                    dist_waddr, dist_raddr;
	logic signed [nj_pkg::DIST_W-1:0] dist_wdata, dist_rdata;
	logic                             sum_we;
	logic [nj_pkg::IDX_W-1:0]         sum_waddr, sum_raddr;
	logic signed [nj_pkg::SUM_W-1:0]  sum_wdata, sum_rdata;
	logic                             sep_we;
	logic [nj_pkg::IDX_W-1:0]         sep_waddr, sep_raddr;
	logic signed [nj_pkg::DIST_W-1:0] sep_wdata, sep_rdata;
	logic                             id_we;
	logic [nj_pkg::IDX_W-1:0]         id_waddr, id_raddr;
	logic [nj_pkg::NODE_W-1:0]        id_wdata, id_rdata;

	nj_pkg::div_req_t div_req;
	nj_pkg::div_rsp_t div_rsp;

	// sequencer registers
	logic [nj_pkg::NODE_W-1:0]        n_q, next_q, cl_q;
	logic [nj_pkg::IDX_W-1:0]         i_q, j_q, m1_q, m2_q, a_q, b_q;
	logic                             found_q, have_q;
	logic signed [33:0]               best_q;
	logic signed [nj_pkg::DIST_W-1:0] sep_i_q, d_q, s1_q, s2_q, v1_q, nd_q;
	logic signed [nj_pkg::SUM_W-1:0]  acc_q, sum_i_q;
	logic signed [32:0]               v12_q;
	logic [nj_pkg::NODE_W-1:0]        id1_q, id2_q;
	logic [nj_pkg::MAX_TAXA-1:0]      active_q;

	logic                             out_valid_q;
	logic [nj_pkg::NODE_W-1:0]        first_node_q, second_node_q;
	logic signed [nj_pkg::DIST_W-1:0] first_branch_q, second_branch_q;
	logic                             last_join_q;
	logic                             out_load;

	// helpers
	logic [nj_pkg::NODE_W-1:0]        n_clamped, nm1_full, cl_m2;
	logic [nj_pkg::IDX_W-1:0]         nm1;
	logic                             i_last, j_last, skip_j, skip_i, out_free, in_take;
	logic [nj_pkg::MAX_TAXA-1:0]      active_init;
	logic signed [33:0]               scan_v;
	logic                             better;
	logic signed [33:0]               t1, t2;
	logic signed [34:0]               c1a, c2a, c1b, c2b;
	logic signed [nj_pkg::DIST_W-1:0] br1, br2, half_d;
	logic signed [33:0]               nd_t, nd_h;
	logic signed [nj_pkg::DIST_W-1:0] nd_calc;
	logic signed [nj_pkg::WIDE_W-1:0] ns_wide;
	logic signed [nj_pkg::SUM_W-1:0]  ns;

	assign n_clamped = (taxa_q < nj_pkg::TAXA_MIN) ? nj_pkg::TAXA_MIN :
	                   (taxa_q > nj_pkg::TAXA_MAX) ? nj_pkg::TAXA_MAX : taxa_q;
	assign nm1_full  = n_q - 7'd1;
	assign nm1       = nm1_full[nj_pkg::IDX_W-1:0];
	assign cl_m2     = cl_q - 7'd2;
	assign i_last    = (i_q == nm1);
	assign j_last    = (j_q == nm1);
	assign skip_j    = !active_q[j_q] || (i_q == j_q);
	assign skip_i    = (i_q == m1_q) || (i_q == m2_q) || !active_q[i_q];
	assign out_free  = !out_valid_q || !out_stall;
	assign in_take   = in_valid && !in_stall;

	always_comb begin
		for (int k = 0; k < nj_pkg::MAX_TAXA; k++) begin
			active_init[k] = (7'(k) < n_clamped);
		end
	end

	// scan metric for the pair in flight
	assign scan_v = {{2{dist_rdata[31]}}, dist_rdata} - {{2{sep_i_q[31]}}, sep_i_q}
	              - {{2{sep_rdata[31]}}, sep_rdata};
	assign better = !found_q || (scan_v < best_q);

	// branch lengths of a join, with optional folding of negative branches
	assign t1 = {{2{d_q[31]}}, d_q} + {{2{s1_q[31]}}, s1_q} - {{2{s2_q[31]}}, s2_q};
	assign t2 = {{2{d_q[31]}}, d_q} + {{2{s2_q[31]}}, s2_q} - {{2{s1_q[31]}}, s1_q};

	always_comb begin
		c1a = {t1[33], t1 >>> 1};
		c2a = {t2[33], t2 >>> 1};
		if (clamp_q && c1a < 0) begin
			c2a = c2a + c1a;
			c1a = '0;
		end
		c1b = c1a;
		c2b = c2a;
		if (clamp_q && c2b < 0) begin
			c1b = c1b + c2b;
			if (c1b < 0) begin
				c1b = '0;
			end
			c2b = '0;
		end
	end

	assign br1    = nj_pkg::sat_dist(42'(c1b));
	assign br2    = nj_pkg::sat_dist(42'(c2b));
	assign half_d = d_q >>> 1;

	// merged distance of row i
	assign nd_t = {{2{v1_q[31]}}, v1_q} + {{2{dist_rdata[31]}}, dist_rdata}
	            - {{2{d_q[31]}}, d_q};

	always_comb begin
		nd_h = nd_t >>> 1;
		if (clamp_q && nd_h < 0) begin
			nd_h = '0;
		end
	end

	assign nd_calc = nj_pkg::sat_dist(42'(nd_h));
	assign ns_wide = 42'(sum_i_q) + 42'(nd_q) - 42'(v12_q);
	assign ns      = nj_pkg::sat_sum(ns_wide);

	// next state and memory control
	always_comb begin
		state_d    = state_q;
		in_stall   = (state_q != nj_pkg::S_IDLE);
		dist_we    = 1'b0;
		dist_waddr = {m1_q, i_q};
		dist_wdata = nd_q;
		dist_raddr = {i_q, j_q};
		sum_we     = 1'b0;
		sum_waddr  = i_q;
		sum_wdata  = acc_q;
		sum_raddr  = i_q;
		sep_we     = 1'b0;
		sep_waddr  = i_q;
		sep_wdata  = div_rsp.quotient;
		sep_raddr  = i_q;
		id_we      = 1'b0;
		id_waddr   = i_q;
		id_wdata   = {1'b0, i_q};
		id_raddr   = m1_q;
		div_req.start    = 1'b0;
		div_req.dividend = acc_q;
		div_req.divisor  = cl_m2[nj_pkg::IDX_W-1:0];
		out_load   = 1'b0;
		case (state_q)
			nj_pkg::S_IDLE: begin
				if (in_valid) begin
					dist_we    = 1'b1;
					dist_waddr = {row_index, column_index};
					dist_wdata = distance_value;
					if (last_entry) begin
						state_d = nj_pkg::S_IN_RD;
					end
				end
			end
			nj_pkg::S_IN_RD: begin
				state_d = nj_pkg::S_IN_ACC;
			end
			nj_pkg::S_IN_ACC: begin
				state_d = j_last ? nj_pkg::S_IN_DIV : nj_pkg::S_IN_RD;
			end
			nj_pkg::S_IN_DIV: begin
				div_req.start   = 1'b1;
				div_req.divisor = nm1 - 6'd1;
				sum_we          = 1'b1;
				state_d         = nj_pkg::S_IN_DIVW;
			end
			nj_pkg::S_IN_DIVW: begin
				if (div_rsp.done) begin
					sep_we  = 1'b1;
					id_we   = 1'b1;
					state_d = i_last ? nj_pkg::S_RND : nj_pkg::S_IN_RD;
				end
			end
			nj_pkg::S_RND: begin
				state_d = (cl_q > 7'd2) ? nj_pkg::S_SC_ROW : nj_pkg::S_FN_SCAN;
			end
			nj_pkg::S_SC_ROW: begin
				if (active_q[i_q]) begin
					state_d = nj_pkg::S_SC_ROWW;
				end else if (i_last) begin
					state_d = nj_pkg::S_JN_RD1;
				end
			end
			nj_pkg::S_SC_ROWW: begin
				state_d = nj_pkg::S_SC_RD;
			end
			nj_pkg::S_SC_RD, nj_pkg::S_SC_CMP: begin
				if (state_q == nj_pkg::S_SC_RD && !skip_j) begin
					sep_raddr = j_q;
					state_d   = nj_pkg::S_SC_CMP;
				end else if (j_last) begin
					state_d = i_last ? nj_pkg::S_JN_RD1 : nj_pkg::S_SC_ROW;
				end else begin
					state_d = nj_pkg::S_SC_RD;
				end
			end
			nj_pkg::S_JN_RD1: begin
				dist_raddr = {m1_q, m2_q};
				sep_raddr  = m1_q;
				state_d    = nj_pkg::S_JN_RD2;
			end
			nj_pkg::S_JN_RD2: begin
				sep_raddr = m2_q;
				id_raddr  = m2_q;
				state_d   = nj_pkg::S_JN_LAT;
			end
			nj_pkg::S_JN_LAT: begin
				state_d = nj_pkg::S_JN_CALC;
			end
			nj_pkg::S_JN_CALC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = nj_pkg::S_MG_CHK;
				end
			end
			nj_pkg::S_MG_CHK: begin
				if (skip_i) begin
					dist_we    = 1'b1;
					dist_wdata = '0;
					state_d    = i_last ? nj_pkg::S_MG_FIN : nj_pkg::S_MG_CHK;
				end else begin
					dist_raddr = {m1_q, i_q};
					state_d    = nj_pkg::S_MG_RD2;
				end
			end
			nj_pkg::S_MG_RD2: begin
				dist_raddr = {m2_q, i_q};
				state_d    = nj_pkg::S_MG_CALC;
			end
			nj_pkg::S_MG_CALC: begin
				state_d = nj_pkg::S_MG_UPD;
			end
			nj_pkg::S_MG_UPD: begin
				sum_we    = 1'b1;
				sum_wdata = ns;
				dist_we   = 1'b1;
				if (cl_q > 7'd2) begin
					div_req.start    = 1'b1;
					div_req.dividend = ns;
					state_d          = nj_pkg::S_MG_DIVW;
				end else begin
					state_d = nj_pkg::S_MG_WR2;
				end
			end
			nj_pkg::S_MG_DIVW: begin
				if (div_rsp.done) begin
					sep_we  = 1'b1;
					state_d = nj_pkg::S_MG_WR2;
				end
			end
			nj_pkg::S_MG_WR2: begin
				dist_we    = 1'b1;
				dist_waddr = {i_q, m1_q};
				state_d    = i_last ? nj_pkg::S_MG_FIN : nj_pkg::S_MG_CHK;
			end
			nj_pkg::S_MG_FIN: begin
				sum_we    = 1'b1;
				sum_waddr = m1_q;
				if (cl_q > 7'd2) begin
					div_req.start = 1'b1;
					state_d       = nj_pkg::S_MG_FDIV;
				end else begin
					state_d = nj_pkg::S_MG_END;
				end
			end
			nj_pkg::S_MG_FDIV: begin
				if (div_rsp.done) begin
					sep_we    = 1'b1;
					sep_waddr = m1_q;
					state_d   = nj_pkg::S_MG_END;
				end
			end
			nj_pkg::S_MG_END: begin
				sum_we    = 1'b1;
				sum_waddr = m2_q;
				sum_wdata = '0;
				id_we     = 1'b1;
				id_waddr  = m1_q;
				id_wdata  = next_q;
				state_d   = nj_pkg::S_RND;
			end
			nj_pkg::S_FN_SCAN: begin
				if (active_q[i_q] && have_q) begin
					state_d = nj_pkg::S_FN_RD;
				end
			end
			nj_pkg::S_FN_RD: begin
				dist_raddr = {a_q, b_q};
				id_raddr   = a_q;
				state_d    = nj_pkg::S_FN_RD2;
			end
			nj_pkg::S_FN_RD2: begin
				id_raddr = b_q;
				state_d  = nj_pkg::S_FN_LAT;
			end
			nj_pkg::S_FN_LAT: begin
				state_d = nj_pkg::S_FN_CALC;
			end
			nj_pkg::S_FN_CALC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = nj_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nj_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nj_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taxa_q  <= nj_pkg::TAXA_RESET;
			clamp_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == nj_pkg::REG_TAXA) begin
				taxa_q <= cfg_data;
			end else if (cfg_index == nj_pkg::REG_CLAMP) begin
				clamp_q <= cfg_data[0];
			end
		end
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		dist_rdata <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		sum_rdata <= sum_mem[sum_raddr];
	end

	always_ff @(posedge clk) begin
		if (sep_we) begin
			sep_mem[sep_waddr] <= sep_wdata;
		end
		sep_rdata <= sep_mem[sep_raddr];
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[id_waddr] <= id_wdata;
		end
		id_rdata <= id_mem[id_raddr];
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= nj_pkg::TAXA_RESET;
			next_q   <= nj_pkg::TAXA_RESET;
			cl_q     <= nj_pkg::TAXA_RESET;
			i_q      <= '0;
			j_q      <= '0;
			found_q  <= 1'b0;
			have_q   <= 1'b0;
			active_q <= '0;
		end else begin
			case (state_q)
				nj_pkg::S_IDLE: begin
					if (in_take && last_entry) begin
						n_q      <= n_clamped;
						i_q      <= '0;
						j_q      <= '0;
						active_q <= active_init;
					end
				end
				nj_pkg::S_IN_ACC: begin
					if (!j_last) begin
						j_q <= j_q + 6'd1;
					end
				end
				nj_pkg::S_IN_DIVW: begin
					if (div_rsp.done) begin
						if (i_last) begin
							next_q <= n_q;
							cl_q   <= n_q;
						end else begin
							i_q <= i_q + 6'd1;
							j_q <= '0;
						end
					end
				end
				nj_pkg::S_RND: begin
					i_q     <= '0;
					j_q     <= '0;
					found_q <= 1'b0;
					have_q  <= 1'b0;
				end
				nj_pkg::S_SC_ROW: begin
					if (!active_q[i_q] && !i_last) begin
						i_q <= i_q + 6'd1;
					end
				end
				nj_pkg::S_SC_ROWW: begin
					j_q <= '0;
				end
				nj_pkg::S_SC_RD, nj_pkg::S_SC_CMP: begin
					if (state_q == nj_pkg::S_SC_CMP && better) begin
						found_q <= 1'b1;
					end
					if (state_q == nj_pkg::S_SC_CMP || skip_j) begin
						if (j_last) begin
							if (!i_last) begin
								i_q <= i_q + 6'd1;
							end
						end else begin
							j_q <= j_q + 6'd1;
						end
					end
				end
				nj_pkg::S_JN_CALC: begin
					if (out_free) begin
						cl_q <= cl_q - 7'd1;
						i_q  <= '0;
					end
				end
				nj_pkg::S_MG_CHK: begin
					if (skip_i && !i_last) begin
						i_q <= i_q + 6'd1;
					end
				end
				nj_pkg::S_MG_WR2: begin
					if (!i_last) begin
						i_q <= i_q + 6'd1;
					end
				end
				nj_pkg::S_MG_END: begin
					active_q[m2_q] <= 1'b0;
					next_q         <= next_q + 7'd1;
				end
				nj_pkg::S_FN_SCAN: begin
					if (active_q[i_q] && !have_q) begin
						have_q <= 1'b1;
					end
					if (!(active_q[i_q] && have_q) && !i_last) begin
						i_q <= i_q + 6'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			nj_pkg::S_IDLE: begin
				acc_q <= '0;
			end
			nj_pkg::S_IN_ACC: begin
				acc_q <= acc_q + {{8{dist_rdata[31]}}, dist_rdata};
			end
			nj_pkg::S_IN_DIVW: begin
				if (div_rsp.done) begin
					acc_q <= '0;
				end
			end
			nj_pkg::S_SC_ROWW: begin
				sep_i_q <= sep_rdata;
			end
			nj_pkg::S_SC_CMP: begin
				if (better) begin
					best_q <= scan_v;
					m1_q   <= i_q;
					m2_q   <= j_q;
				end
			end
			nj_pkg::S_JN_RD2: begin
				d_q  <= dist_rdata;
				s1_q <= sep_rdata;
				id1_q <= id_rdata;
			end
			nj_pkg::S_JN_LAT: begin
				s2_q  <= sep_rdata;
				id2_q <= id_rdata;
			end
			nj_pkg::S_JN_CALC: begin
				acc_q <= '0;
			end
			nj_pkg::S_MG_RD2: begin
				v1_q    <= dist_rdata;
				sum_i_q <= sum_rdata;
			end
			nj_pkg::S_MG_CALC: begin
				nd_q  <= nd_calc;
				v12_q <= {v1_q[31], v1_q} + {dist_rdata[31], dist_rdata};
			end
			nj_pkg::S_MG_UPD: begin
				acc_q <= acc_q + {{8{nd_q[31]}}, nd_q};
			end
			nj_pkg::S_FN_SCAN: begin
				if (active_q[i_q]) begin
					if (have_q) begin
						b_q <= i_q;
					end else begin
						a_q <= i_q;
					end
				end
			end
			nj_pkg::S_FN_RD2: begin
				d_q   <= dist_rdata;
				id1_q <= id_rdata;
			end
			nj_pkg::S_FN_LAT: begin
				id2_q <= id_rdata;
			end
			default: begin
			end
		endcase
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			first_node_q  <= id1_q;
			second_node_q <= id2_q;
			if (state_q == nj_pkg::S_FN_CALC) begin
				first_branch_q  <= half_d;
				second_branch_q <= half_d;
				last_join_q     <= 1'b1;
			end else begin
				first_branch_q  <= br1;
				second_branch_q <= br2;
				last_join_q     <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign first_node    = first_node_q;
	assign second_node   = second_node_q;
	assign first_branch  = first_branch_q;
	assign second_branch = second_branch_q;
	assign last_join     = last_join_q;

	nj_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

@@ design/nj_chk.sv @@
// Port-level assertion checker for the neighbour joining block, with its bind.
`timescale 1ns / 1ps
`include "neighbour_joining_tree_assert.svh"
module nj_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             last_entry,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [nj_pkg::NODE_W-1:0]        first_node,
	input logic [nj_pkg::NODE_W-1:0]        second_node,
	input logic signed [nj_pkg::DIST_W-1:0] first_branch,
	input logic signed [nj_pkg::DIST_W-1:0] second_branch,
	input logic                             last_join
);

	// hold a stalled result beat
	`NJT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(first_node) && $stable(second_node) && $stable(first_branch) && $stable(second_branch) && $stable(last_join), "stalled result beat changed")

	`NJT_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && last_entry, in_stall, "input taken right after the final matrix beat")

	`NJT_ASSERT_NOW(a_distinct_nodes, out_valid, first_node != second_node, "join names the same node twice")

	// a join short of the last one means the tree is still being built
	`NJT_ASSERT_NOW(a_busy_mid_tree, out_valid && !last_join, in_stall, "input open while the tree build is running")

endmodule

bind neighbour_joining_tree nj_chk u_nj_chk (.*);

@@ bench/tb_neighbour_joining_tree.sv @@
// Self-checking bench for the neighbour joining block: matrix loads, tree builds, join checks.
`timescale 1ns / 1ps
module tb_neighbour_joining_tree;
	import nj_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DIST_W-1:0] dval;
		logic                     last;
	} entry_t;

	typedef struct {
		logic [NODE_W-1:0]        node_a;
		logic [NODE_W-1:0]        node_b;
		logic signed [DIST_W-1:0] branch_a;
		logic signed [DIST_W-1:0] branch_b;
		logic                     last;
	} join_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we, cfg_index;
	logic [6:0] cfg_data;
	logic in_valid, in_stall;
	logic [IDX_W-1:0] row_index, column_index;
	logic signed [DIST_W-1:0] distance_value;
	logic last_entry;
	logic out_valid, out_stall;
	logic [NODE_W-1:0] first_node, second_node;
	logic signed [DIST_W-1:0] first_branch, second_branch;
	logic last_join;

	neighbour_joining_tree u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	entry_t pending_entries[$];
	join_t expected_joins[$];
	int errors = 0;
	bit no_gaps = 0;

	// mirror of the block's state
	longint dist_mem[MAX_TAXA*MAX_TAXA];
	bit loaded[MAX_TAXA*MAX_TAXA];
	longint sep_sum[MAX_TAXA];
	longint sep[MAX_TAXA];
	int node_id[MAX_TAXA];
	bit alive[MAX_TAXA];
	int taxa_reg = 32;
	bit clamp_reg = 0;

	function automatic longint sat_bits(longint x, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return x > hi ? hi : (x < lo ? lo : x);
	endfunction

	function automatic int taxa_in_use(int t);
		return t < 3 ? 3 : (t > MAX_TAXA ? MAX_TAXA : t);
	endfunction

	function automatic void push_join(int a, int b, longint ba, longint bb, bit last);
		join_t j;
		j.node_a = a[NODE_W-1:0];
		j.node_b = b[NODE_W-1:0];
		j.branch_a = DIST_W'(sat_bits(ba, 32));
		j.branch_b = DIST_W'(sat_bits(bb, 32));
		j.last = last;
		expected_joins.push_back(j);
	endfunction

	// Saitou-Nei joining on the mirrored matrix, queuing every join it emits
	function automatic void join_tree();
		int n, i, j, m1, m2, left, next_id, a, b;
		longint s, best, v, d, d1, d2, s1, s2, newsum, v1, v2, nd;
		bit found, have1;
		n = taxa_in_use(taxa_reg);
		m1 = 0;
		m2 = 1;
		for (i = 0; i < n; i++) begin
			s = 0;
			for (j = 0; j < n; j++) s += dist_mem[i*MAX_TAXA+j];
			sep_sum[i] = sat_bits(s, SUM_W);
			sep[i] = sat_bits(sep_sum[i] / longint'(n - 2), DIST_W);
			node_id[i] = i;
			alive[i] = 1;
		end
		for (i = n; i < MAX_TAXA; i++) alive[i] = 0;
		next_id = n;
		left = n;
		while (left > 2) begin
			found = 0;
			best = 0;
			newsum = 0;
			for (i = 0; i < n; i++) begin
				if (!alive[i]) continue;
				for (j = 0; j < n; j++) begin
					if (!alive[j] || i == j) continue;
					v = dist_mem[i*MAX_TAXA+j] - sep[i] - sep[j];
					if (!found || v < best) begin
						found = 1;
						best = v;
						m1 = i;
						m2 = j;
					end
				end
			end
			d = dist_mem[m1*MAX_TAXA+m2];
			s1 = sep[m1];
			s2 = sep[m2];
			d1 = (d + s1 - s2) >>> 1;
			d2 = (d + s2 - s1) >>> 1;
			if (clamp_reg) begin
				if (d1 < 0) begin
					d2 += d1;
					d1 = 0;
				end
				if (d2 < 0) begin
					d1 += d2;
					if (d1 < 0) d1 = 0;
					d2 = 0;
				end
			end
			push_join(node_id[m1], node_id[m2], d1, d2, 0);
			left--;
			for (i = 0; i < n; i++) begin
				if (i == m1 || i == m2 || !alive[i]) begin
					dist_mem[m1*MAX_TAXA+i] = 0;
				end else begin
					v1 = dist_mem[m1*MAX_TAXA+i];
					v2 = dist_mem[m2*MAX_TAXA+i];
					nd = (v1 + v2 - d) >>> 1;
					if (clamp_reg && nd < 0) nd = 0;
					nd = sat_bits(nd, DIST_W);
					newsum += nd;
					sep_sum[i] = sat_bits(sep_sum[i] + nd - v1 - v2, SUM_W);
					if (left > 2) sep[i] = sat_bits(sep_sum[i] / longint'(left - 2), DIST_W);
					dist_mem[m1*MAX_TAXA+i] = nd;
					dist_mem[i*MAX_TAXA+m1] = nd;
				end
			end
			sep_sum[m1] = sat_bits(newsum, SUM_W);
			if (left > 2) sep[m1] = sat_bits(sep_sum[m1] / longint'(left - 2), DIST_W);
			sep_sum[m2] = 0;
			alive[m2] = 0;
			node_id[m1] = next_id & 8'h7F;
			next_id = (next_id + 1) & 8'h7F;
		end
		have1 = 0;
		a = 0;
		b = 0;
		for (i = 0; i < n; i++) begin
			if (!alive[i]) continue;
			if (!have1) begin
				a = i;
				have1 = 1;
			end else begin
				b = i;
				break;
			end
		end
		d = dist_mem[a*MAX_TAXA+b] >>> 1;
		push_join(node_id[a], node_id[b], d, d, 1);
	endfunction

	// driver: one beat at a time from the pending queue, random gaps between beats
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		entry_t e;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				dist_mem[row_index*MAX_TAXA+column_index] = longint'(distance_value);
				loaded[row_index*MAX_TAXA+column_index] = 1;
				if (last_entry) join_tree();
			end
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_entries.size() > 0) begin
				e = pending_entries.pop_front();
				row_index <= e.row;
				column_index <= e.col;
				distance_value <= e.dval;
				last_entry <= e.last;
				in_valid <= 1'b1;
				in_gap = no_gaps ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each join beat with the oldest expectation, random stalls
	int out_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		join_t x;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_joins.size() == 0) begin
					$display("%0t: unexpected join %0d/%0d", $time, first_node, second_node);
					errors++;
				end else begin
					x = expected_joins.pop_front();
					if (first_node !== x.node_a || second_node !== x.node_b ||
					    first_branch !== x.branch_a || second_branch !== x.branch_b ||
					    last_join !== x.last) begin
						$display("%0t: join mismatch exp %0d %0d %0d %0d %0d act %0d %0d %0d %0d %0d",
							$time, x.node_a, x.node_b, x.branch_a, x.branch_b, x.last,
							first_node, second_node, first_branch, second_branch, last_join);
						errors++;
					end
				end
				out_hold = no_gaps ? 0 : $urandom_range(0, 4);
			end
			out_stall <= (out_hold > 0);
			if (out_hold > 0) out_hold--;
		end
	end

	// watchdog on cycles without any beat
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_neighbour_joining_tree failed");
			$finish;
		end
	end

	task automatic write_reg(logic idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[6:0];
		if (idx == REG_TAXA) taxa_reg = value & 8'h7F;
		else clamp_reg = value[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_entries.size() != 0 || in_valid || expected_joins.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [DIST_W-1:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// queue an n-by-n load: 0 random symmetric, 1 full random, 2 corner values;
	// trail puts the last mark on an extra beat outside the matrix
	function automatic void queue_matrix(int n, int kind, bit trail);
		entry_t e;
		logic signed [DIST_W-1:0] sym[MAX_TAXA][MAX_TAXA];
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				e.row = IDX_W'(r);
				e.col = IDX_W'(c);
				if (kind == 1) e.dval = $urandom;
				else if (kind == 2) e.dval = corner_value();
				else if (r == c) e.dval = 0;
				else if (r < c) e.dval = $urandom_range(1, 200 * 65536);
				else e.dval = sym[c][r];
				sym[r][c] = e.dval;
				e.last = !trail && r == n - 1 && c == n - 1;
				pending_entries.push_back(e);
			end
		end
		if (trail) begin
			e.row = IDX_W'(63);
			e.col = IDX_W'($urandom_range(n, 63));
			e.dval = $urandom;
			e.last = 1;
			pending_entries.push_back(e);
		end
	endfunction

	function automatic bit matrix_loaded(int n);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (!loaded[r*MAX_TAXA+c]) return 0;
		return 1;
	endfunction

	initial begin
		int sent, n, kind;
		entry_t e;
		cfg_we = 1'b0;
		cfg_index = REG_TAXA;
		cfg_data = '0;
		row_index = '0;
		column_index = '0;
		distance_value = '0;
		last_entry = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corner values, clamping, trailing start, rebuild without reload
		write_reg(REG_TAXA, 3);
		write_reg(REG_CLAMP, 0);
		queue_matrix(3, 2, 0);
		drain();
		write_reg(REG_CLAMP, 1);
		queue_matrix(3, 2, 1);
		drain();
		write_reg(REG_TAXA, 0);
		e.row = IDX_W'(63);
		e.col = IDX_W'(63);
		e.dval = 32'sh80000000;
		e.last = 1;
		pending_entries.push_back(e);
		drain();
		write_reg(REG_TAXA, 4);
		write_reg(REG_CLAMP, 0);
		queue_matrix(4, 1, 0);
		drain();

		// random phases on small matrices
		sent = 0;
		while (sent < 100) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			n = $urandom_range(3, 8);
			kind = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
			write_reg(REG_TAXA, (n == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : n);
			write_reg(REG_CLAMP, $urandom_range(0, 1));
			if (matrix_loaded(n) && $urandom_range(0, 5) == 0) begin
				e.row = IDX_W'(62);
				e.col = IDX_W'(63);
				e.dval = $urandom;
				e.last = 1;
				pending_entries.push_back(e);
				sent += 1;
			end else begin
				queue_matrix(n, kind, $urandom_range(0, 4) == 0);
				sent += n * n;
			end
			drain();
		end

		// one larger build
		no_gaps = 0;
		write_reg(REG_TAXA, 9);
		write_reg(REG_CLAMP, 1);
		queue_matrix(9, 0, 0);
		drain();

		if (errors == 0) begin
			$display("tb_neighbour_joining_tree passed");
		end else begin
			$display("tb_neighbour_joining_tree failed");
		end
		$finish;
	end

endmodule
